### src/line_follower_pid_drive_unit_defines.svh
// ----------------------------------------------------------------------------
// Line follower PID drive unit: assertion macros
// Shared concurrent assertion forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_PID_DRIVE_UNIT_DEFINES_SVH
`define LINE_FOLLOWER_PID_DRIVE_UNIT_DEFINES_SVH

// same-cycle implication
`define LFPD_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lfpd assertion failed");

// next-cycle implication
`define LFPD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lfpd assertion failed");

`endif

### src/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// Line follower PID drive: package
// Widths, register codes, configuration record and the decay table.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int SAMPLE_BITS  = 12;
   localparam int ERR_BITS     = 17;
   localparam int EXP_ENTRIES  = 256;
   localparam int IDX_BITS     = $clog2(EXP_ENTRIES);
   localparam int QUEUE_DEPTH  = 2;
   localparam int EXP_RATIO    = 61565;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_DECAY = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SPEED   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SPEED   = 3'd5;

   localparam logic [15:0] PROP_GAIN_RESET   = 16'd983;
   localparam logic [15:0] INTEG_GAIN_RESET  = 16'd20;
   localparam logic [15:0] DERIV_GAIN_RESET  = 16'd13107;
   localparam logic [15:0] SPEED_DECAY_RESET = 16'd4588;
   localparam logic [7:0]  MIN_SPEED_RESET   = 8'd80;
   localparam logic [7:0]  MAX_SPEED_RESET   = 8'd150;

   typedef struct packed {
      logic [15:0] prop_gain;
      logic [15:0] integ_gain;
      logic [15:0] deriv_gain;
      logic [15:0] speed_decay;
      logic [7:0]  min_speed;
      logic [7:0]  max_speed;
   } cfg_type;

   typedef logic [16:0] decay_rom_type [EXP_ENTRIES];

   function automatic decay_rom_type build_decay_rom();
      decay_rom_type rom;
      logic [63:0]   val;
      val = 64'd65536;
      for (int k = 0; k < EXP_ENTRIES; k++) begin
         rom[k] = val[16:0];
         val    = (val * 64'(EXP_RATIO) + 64'd32768) >> 16;
      end
      return rom;
   endfunction

   localparam decay_rom_type DECAY_ROM = build_decay_rom();

   function automatic logic signed [4:0] sensor_weight(input int k);
      return 5'(2 * k - (SENSOR_COUNT - 1));
   endfunction

endpackage

### src/lfpd_front.sv
// ----------------------------------------------------------------------------
// Line follower PID drive: front end
// Accepts a sensor scan and forms the weighted position error.
// ----------------------------------------------------------------------------
module lfpd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]    sample [lfpd_pkg::SENSOR_COUNT],
   output logic                                push,
   output logic signed [lfpd_pkg::ERR_BITS-1:0] push_err,
   input  logic                                q_full
);
   import lfpd_pkg::*;

   logic                       err_valid_ff;
   logic signed [ERR_BITS-1:0] err_ff;
   logic signed [ERR_BITS:0]   err_in;
   logic                       accept;

   always_comb begin
      logic signed [ERR_BITS:0] sample_ext;
      logic signed [ERR_BITS:0] weight_ext;
      err_in = '0;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
         sample_ext = $signed({{(ERR_BITS + 1 - SAMPLE_BITS){1'b0}}, sample[k]});
         weight_ext = (ERR_BITS + 1)'(sensor_weight(k));
         err_in     = err_in + sample_ext * weight_ext;
      end
   end

   assign req_stall = err_valid_ff & q_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = err_valid_ff & ~q_full;
   assign push_err  = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_valid_ff <= 1'b0;
      end else if (accept) begin
         err_valid_ff <= 1'b1;
      end else if (push) begin
         err_valid_ff <= 1'b0;
      end
      if (accept) begin
         err_ff <= err_in[ERR_BITS-1:0];
      end
   end

endmodule

### src/lfpd_queue.sv
// ----------------------------------------------------------------------------
// Line follower PID drive: error queue
// Short FIFO of position errors between front and back ends.
// ----------------------------------------------------------------------------
module lfpd_queue #(
   parameter int DEPTH = lfpd_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  logic signed [lfpd_pkg::ERR_BITS-1:0] push_err,
   output logic                                 full,
   input  logic                                 pop,
   output logic signed [lfpd_pkg::ERR_BITS-1:0] pop_err,
   output logic                                 empty
);
   import lfpd_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic signed [ERR_BITS-1:0] entries_ff [DEPTH];
   logic [PTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]      count_ff;

   assign full    = (count_ff == COUNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_err = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_err;
      end
   end

endmodule

### src/lfpd_back.sv
// ----------------------------------------------------------------------------
// Line follower PID drive: back end
// Integral, PID sum, base speed and drive clamp on one shared multiplier.
// ----------------------------------------------------------------------------
module lfpd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lfpd_pkg::cfg_type                    cfg,
   input  logic                                 q_empty,
   input  logic signed [lfpd_pkg::ERR_BITS-1:0] q_err,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_left_duty,
   output logic                                 rsp_left_reverse,
   output logic [7:0]                           rsp_right_duty,
   output logic                                 rsp_right_reverse,
   output logic signed [lfpd_pkg::ERR_BITS-1:0] rsp_position_error,
   output logic [7:0]                           rsp_base_speed
);
   import lfpd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INTEG, ST_MUL_P, ST_MUL_I, ST_MUL_D,
      ST_MUL_G, ST_MUL_X, ST_MUL_B, ST_OUT
   } state_type;

   function automatic logic signed [34:0] q16_trunc(input logic signed [50:0] v);
      logic signed [50:0] biased;
      biased = v + (v[50] ? 51'sd65535 : 51'sd0);
      return biased[50:16];
   endfunction

   function automatic logic signed [8:0] clamp_drive(input logic signed [35:0] v);
      if (v > 36'sd255) begin
         return 9'sd255;
      end else if (v < -36'sd255) begin
         return -9'sd255;
      end
      return v[8:0];
   endfunction

   state_type                  state_ff;
   logic signed [ERR_BITS-1:0] err_ff;
   logic signed [31:0]         integ_ff, integ_in;
   logic signed [17:0]         prev_ff;
   logic signed [31:0]         ival_ff;
   logic signed [17:0]         deriv_ff, deriv_in;
   logic signed [50:0]         prod_ff, prod_in;
   logic signed [50:0]         acc_ff;
   logic signed [34:0]         u_ff, u_in;
   logic                       rsp_valid_ff;
   logic [7:0]                 left_duty_ff, right_duty_ff, base_ff;
   logic                       left_rev_ff, right_rev_ff;
   logic signed [ERR_BITS-1:0] pos_err_ff;

   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [32:0] isum;
   logic signed [31:0] isat;
   logic               err_pos, err_neg;
   logic [16:0]        mag;
   logic signed [8:0]  diff;
   logic [22:0]        idx_full;
   logic [16:0]        factor;
   logic signed [34:0] q_base;
   logic signed [9:0]  base_sum;
   logic signed [35:0] base_ext, u_ext;
   logic signed [8:0]  left_c, right_c, left_neg, right_neg;
   logic               out_free;

   assign err_pos = ~err_ff[ERR_BITS-1] & (err_ff != '0);
   assign err_neg = err_ff[ERR_BITS-1];

   always_comb begin
      isum = {integ_ff[31], integ_ff} + {{(33 - ERR_BITS){err_ff[ERR_BITS-1]}}, err_ff};
      priority case (isum[32:31])
         2'b01:   isat = 32'sh7FFF_FFFF;
         2'b10:   isat = 32'sh8000_0000;
         default: isat = isum[31:0];
      endcase
      if ((err_pos && isat < 0) || (err_neg && isat > 0)) begin
         integ_in = '0;
      end else begin
         integ_in = isat;
      end
      deriv_in = {err_ff[ERR_BITS-1], err_ff} - prev_ff;
   end

   assign mag      = err_ff[ERR_BITS-1] ? 17'(-err_ff) : 17'(err_ff);
   assign diff     = $signed({1'b0, cfg.max_speed}) - $signed({1'b0, cfg.min_speed});
   assign idx_full = prod_ff[50:28];
   assign factor   = (idx_full < 23'(EXP_ENTRIES)) ? DECAY_ROM[idx_full[IDX_BITS-1:0]] : '0;

   always_comb begin
      unique case (state_ff)
         ST_MUL_P: begin
            mul_a = {17'b0, cfg.prop_gain};
            mul_b = {err_ff[ERR_BITS-1], err_ff};
         end
         ST_MUL_I: begin
            mul_a = {ival_ff[31], ival_ff};
            mul_b = {2'b0, cfg.integ_gain};
         end
         ST_MUL_D: begin
            mul_a = {17'b0, cfg.deriv_gain};
            mul_b = deriv_ff;
         end
         ST_MUL_G: begin
            mul_a = {17'b0, cfg.speed_decay};
            mul_b = {2'b0, cfg.prop_gain};
         end
         ST_MUL_X: begin
            mul_a = prod_ff[32:0];
            mul_b = {1'b0, mag};
         end
         ST_MUL_B: begin
            mul_a = {{24{diff[8]}}, diff};
            mul_b = {1'b0, factor};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = $signed({{18{mul_a[32]}}, mul_a}) * $signed({{33{mul_b[17]}}, mul_b});
   assign u_in    = q16_trunc(acc_ff);

   assign q_base    = q16_trunc(prod_ff);
   assign base_sum  = $signed({2'b0, cfg.min_speed}) + q_base[9:0];
   assign base_ext  = {{26{base_sum[9]}}, base_sum};
   assign u_ext     = {u_ff[34], u_ff};
   assign left_c    = clamp_drive(base_ext + u_ext);
   assign right_c   = clamp_drive(base_ext - u_ext);
   assign left_neg  = -left_c;
   assign right_neg = -right_c;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign pop      = (state_ff == ST_IDLE) & ~q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         integ_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  err_ff   <= q_err;
                  state_ff <= ST_INTEG;
               end
            end
            ST_INTEG: begin
               integ_ff <= integ_in;
               ival_ff  <= integ_in;
               prev_ff  <= {err_ff[ERR_BITS-1], err_ff};
               deriv_ff <= deriv_in;
               state_ff <= ST_MUL_P;
            end
            ST_MUL_P: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_I;
            end
            ST_MUL_I: begin
               acc_ff   <= prod_ff;
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_D;
            end
            ST_MUL_D: begin
               acc_ff   <= acc_ff + prod_ff;
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_G;
            end
            ST_MUL_G: begin
               acc_ff   <= acc_ff + prod_ff;
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_X;
            end
            ST_MUL_X: begin
               u_ff     <= u_in;
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_B;
            end
            ST_MUL_B: begin
               prod_ff  <= prod_in;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  left_duty_ff  <= left_c[8] ? left_neg[7:0] : left_c[7:0];
                  left_rev_ff   <= left_c[8];
                  right_duty_ff <= right_c[8] ? right_neg[7:0] : right_c[7:0];
                  right_rev_ff  <= right_c[8];
                  pos_err_ff    <= err_ff;
                  base_ff       <= base_sum[7:0];
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_duty      = left_duty_ff;
   assign rsp_left_reverse   = left_rev_ff;
   assign rsp_right_duty     = right_duty_ff;
   assign rsp_right_reverse  = right_rev_ff;
   assign rsp_position_error = pos_err_ff;
   assign rsp_base_speed     = base_ff;

endmodule

### src/line_follower_pid_drive_unit.sv
// ----------------------------------------------------------------------------
// Line follower PID drive unit
// PID steering with anti-windup and error-dependent base speed.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_sample_0 .. req_sample_7
//  rsp      out        rsp_valid/rsp_stall  duty, reverse, error, base speed
//  csr      in         csr_write            csr_index, csr_data
//
//  The back end takes one scan at a time through its shared multiplier
//  sequence. Synchronous reset restores register defaults, clears integral
//  and previous error. A stalled result holds the back end; the front end
//  and queue keep taking scans until the queue fills.
// ----------------------------------------------------------------------------
module line_follower_pid_drive_unit #(
   parameter int QUEUE_DEPTH = lfpd_pkg::QUEUE_DEPTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]        req_sample_0,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]        req_sample_1,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]        req_sample_2,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]        req_sample_3,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]        req_sample_4,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]        req_sample_5,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]        req_sample_6,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]        req_sample_7,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [7:0]                              rsp_left_duty,
   output logic                                    rsp_left_reverse,
   output logic [7:0]                              rsp_right_duty,
   output logic                                    rsp_right_reverse,
   output logic signed [lfpd_pkg::ERR_BITS-1:0]    rsp_position_error,
   output logic [7:0]                              rsp_base_speed,
   input  logic                                    csr_write,
   input  logic [lfpd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lfpd_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import lfpd_pkg::*;

   cfg_type                    cfg_ff;
   logic [SAMPLE_BITS-1:0]     sample [SENSOR_COUNT];
   logic                       push, q_full, q_empty, pop;
   logic signed [ERR_BITS-1:0] push_err, q_err;

   assign sample[0] = req_sample_0;
   assign sample[1] = req_sample_1;
   assign sample[2] = req_sample_2;
   assign sample[3] = req_sample_3;
   assign sample[4] = req_sample_4;
   assign sample[5] = req_sample_5;
   assign sample[6] = req_sample_6;
   assign sample[7] = req_sample_7;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= PROP_GAIN_RESET;
         cfg_ff.integ_gain  <= INTEG_GAIN_RESET;
         cfg_ff.deriv_gain  <= DERIV_GAIN_RESET;
         cfg_ff.speed_decay <= SPEED_DECAY_RESET;
         cfg_ff.min_speed   <= MIN_SPEED_RESET;
         cfg_ff.max_speed   <= MAX_SPEED_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PROP_GAIN:   cfg_ff.prop_gain   <= csr_data;
            CSR_INTEG_GAIN:  cfg_ff.integ_gain  <= csr_data;
            CSR_DERIV_GAIN:  cfg_ff.deriv_gain  <= csr_data;
            CSR_SPEED_DECAY: cfg_ff.speed_decay <= csr_data;
            CSR_MIN_SPEED:   cfg_ff.min_speed   <= csr_data[7:0];
            CSR_MAX_SPEED:   cfg_ff.max_speed   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   lfpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sample    (sample),
      .push      (push),
      .push_err  (push_err),
      .q_full    (q_full)
   );

   lfpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_err (push_err),
      .full     (q_full),
      .pop      (pop),
      .pop_err  (q_err),
      .empty    (q_empty)
   );

   lfpd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_empty            (q_empty),
      .q_err              (q_err),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_duty      (rsp_left_duty),
      .rsp_left_reverse   (rsp_left_reverse),
      .rsp_right_duty     (rsp_right_duty),
      .rsp_right_reverse  (rsp_right_reverse),
      .rsp_position_error (rsp_position_error),
      .rsp_base_speed     (rsp_base_speed)
   );

endmodule

### src/lfpd_checker.sv
// ----------------------------------------------------------------------------
// Line follower PID drive: port checker
// Result channel properties seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "line_follower_pid_drive_unit_defines.svh"

module lfpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_left_duty,
   input logic       rsp_left_reverse,
   input logic [7:0] rsp_right_duty,
   input logic       rsp_right_reverse
);

   `LFPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `LFPD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `LFPD_ASSERT_IMP(a_not_both_reverse, clock, reset, rsp_valid, !(rsp_left_reverse && rsp_right_reverse))
   `LFPD_ASSERT_IMP(a_reverse_nonzero, clock, reset, rsp_valid, (!rsp_left_reverse || rsp_left_duty != 8'd0) && (!rsp_right_reverse || rsp_right_duty != 8'd0))

endmodule

bind line_follower_pid_drive_unit lfpd_checker u_checker (.*);
